@@ hdl/rcp_pkg.sv @@
// shared constants and result type for the request command parser
package rcp_pkg;

    // field widths of the count and length lines
    localparam int COUNT_BITS = 16;
    localparam int LEN_BITS   = 32;
    localparam int ACC_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // one result item
    typedef struct packed {
        logic [7:0] arg_byte;
        logic       has_byte;
        logic       arg_first;
        logic       arg_last;
        logic       cmd_last;
        logic       parse_error;
        logic       run_last;
    } t_result;

    // build a result item with run_last clear
    function automatic t_result mk_res(logic [7:0] b, logic has, logic first, logic last,
                                       logic cmd, logic err);
        t_result r;
        r.arg_byte    = b;
        r.has_byte    = has;
        r.arg_first   = first;
        r.arg_last    = last;
        r.cmd_last    = cmd;
        r.parse_error = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/resp_command_parser.sv @@
// request command parser: byte stream in, argument items out
// A byte goes from the input register through the parse step into the result queue.
// Throughput: one byte per cycle; the byte-parse stage runs whenever the input register
// holds a byte and the 4-entry result queue holds at most 2 items, so a byte that causes
// two results can hold the input back when the output side takes one item a cycle.
// Reset: i_rst_n synchronous active low; parser state returns to idle between commands,
// input register and result queue empty, no clearing pass.
module resp_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_arg_byte,
    output logic       o_has_byte,
    output logic       o_arg_first,
    output logic       o_arg_last,
    output logic       o_cmd_last,
    output logic       o_parse_error,
    output logic       o_run_last
);
    import rcp_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_COUNT, M_COUNT_LF, M_DOLLAR, M_LEN, M_LEN_LF,
        M_PAYLOAD, M_SKIP_A, M_SKIP_B, M_INLINE, M_DISCARD
    } t_mode;

    // inline tokenizer state
    typedef struct packed {
        logic [7:0] held_byte;
        logic       held_valid;
        logic       held_ends;
        logic       at_arg_start;
    } t_inl;

    typedef struct packed {
        t_inl    st;
        logic    emit;
        t_result res;
    } t_inl_ret;

    // one non-framing byte of an inline line
    function automatic t_inl_ret inline_char(t_inl s, logic [7:0] c);
        t_inl_ret r;
        r.st   = s;
        r.emit = 1'b0;
        r.res  = '0;
        if (c == CH_SPACE) begin
            if (s.held_valid) r.st.held_ends = 1'b1;
        end else begin
            r.st.at_arg_start = 1'b1;
            if (s.held_valid) begin
                r.emit = 1'b1;
                r.res  = mk_res(s.held_byte, 1'b1, s.at_arg_start, s.held_ends, 1'b0, 1'b0);
                r.st.at_arg_start = s.held_ends;
            end
            r.st.held_byte  = c;
            r.st.held_valid = 1'b1;
            r.st.held_ends  = 1'b0;
        end
        return r;
    endfunction

    localparam t_inl INL_CLEAR = '{held_byte: 8'h00, held_valid: 1'b0,
                                   held_ends: 1'b0, at_arg_start: 1'b1};

    // registers
    t_mode                 r_mode, n_mode;
    logic [COUNT_BITS-1:0] r_elems, n_elems;
    logic [LEN_BITS-1:0]   r_payl, n_payl;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    t_inl                  r_inl, n_inl;
    logic                  r_cr_held, n_cr_held;
    logic                  r_digit_seen, n_digit_seen;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    t_result               r_fifo [Q_DEPTH];
    logic [Q_AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]         r_count;

    // handshake and parse enable
    logic proceed, pop;
    assign proceed     = r_in_valid && (r_count <= (Q_AW+1)'(Q_DEPTH - 2));
    assign o_in_ready  = !r_in_valid || proceed;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;

    // per-byte parse step
    logic                  em_a_v, em_b_v;
    t_result               em_a, em_b;
    t_result               e0, e1;
    logic [1:0]            e_cnt;
    logic [7:0]            c;
    logic                  is_digit, overflow;
    logic [ACC_BITS+3:0]   nxt;
    t_inl_ret              ir1, ir2;

    always_comb begin
        c            = r_in_byte;
        n_mode       = r_mode;
        n_elems      = r_elems;
        n_payl       = r_payl;
        n_acc        = r_acc;
        n_inl        = r_inl;
        n_cr_held    = r_cr_held;
        n_digit_seen = r_digit_seen;
        em_a_v       = 1'b0;
        em_b_v       = 1'b0;
        em_a         = '0;
        em_b         = '0;
        ir1          = '0;
        ir2          = '0;

        // decimal digit accumulate with range check
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        nxt = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (ACC_BITS+4)'(c[3:0]);
        if (r_mode == M_COUNT) overflow = |nxt[ACC_BITS+3:COUNT_BITS];
        else                   overflow = |nxt[ACC_BITS+3:LEN_BITS];

        case (r_mode)
            M_IDLE: begin
                if (c == CH_STAR) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b0;
                    n_mode       = M_COUNT;
                end else if (c != CH_CR && c != CH_LF) begin
                    // a cleared holder never emits here
                    ir1       = inline_char(INL_CLEAR, c);
                    n_inl     = ir1.st;
                    n_cr_held = 1'b0;
                    n_mode    = M_INLINE;
                end
            end
            M_COUNT, M_LEN: begin
                if (c == CH_CR && r_digit_seen) begin
                    n_mode = (r_mode == M_COUNT) ? M_COUNT_LF : M_LEN_LF;
                end else if (is_digit && !overflow) begin
                    n_acc        = nxt[ACC_BITS-1:0];
                    n_digit_seen = 1'b1;
                end else begin
                    em_a_v = 1'b1;
                end
            end
            M_COUNT_LF: begin
                if (c != CH_LF) begin
                    em_a_v = 1'b1;
                end else if (r_acc == '0) begin
                    em_a_v = 1'b1;
                    em_a   = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    n_elems = r_acc[COUNT_BITS-1:0];
                    n_mode  = M_DOLLAR;
                end
            end
            M_DOLLAR: begin
                if (c == CH_DOLLAR) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b0;
                    n_mode       = M_LEN;
                end else begin
                    em_a_v = 1'b1;
                end
            end
            M_LEN_LF: begin
                if (c != CH_LF) begin
                    em_a_v = 1'b1;
                end else if (r_acc == '0) begin
                    em_a_v = 1'b1;
                    em_a   = mk_res(8'h00, 1'b0, 1'b1, 1'b1,
                                    r_elems == COUNT_BITS'(1), 1'b0);
                    n_mode = M_SKIP_A;
                end else begin
                    n_payl             = r_acc[LEN_BITS-1:0];
                    n_inl.at_arg_start = 1'b1;
                    n_mode             = M_PAYLOAD;
                end
            end
            M_PAYLOAD: begin
                em_a_v = 1'b1;
                if (r_payl <= LEN_BITS'(1)) begin
                    em_a = mk_res(c, 1'b1, r_inl.at_arg_start, 1'b1,
                                  r_elems == COUNT_BITS'(1), 1'b0);
                    n_payl             = '0;
                    n_inl.at_arg_start = 1'b1;
                    n_mode             = M_SKIP_A;
                end else begin
                    em_a = mk_res(c, 1'b1, r_inl.at_arg_start, 1'b0, 1'b0, 1'b0);
                    n_payl             = r_payl - LEN_BITS'(1);
                    n_inl.at_arg_start = 1'b0;
                end
            end
            M_SKIP_A: begin
                n_mode = M_SKIP_B;
            end
            M_SKIP_B: begin
                if (r_elems > COUNT_BITS'(1)) begin
                    n_elems = r_elems - COUNT_BITS'(1);
                    n_mode  = M_DOLLAR;
                end else begin
                    n_elems = '0;
                    n_mode  = M_IDLE;
                end
            end
            M_INLINE: begin
                if (c == CH_LF) begin
                    if (r_inl.held_valid) begin
                        em_a_v = 1'b1;
                        em_a   = mk_res(r_inl.held_byte, 1'b1, r_inl.at_arg_start,
                                        1'b1, 1'b1, 1'b0);
                    end
                    n_inl     = INL_CLEAR;
                    n_cr_held = 1'b0;
                    n_mode    = M_IDLE;
                end else if (c == CH_CR) begin
                    // a second CR turns the held one into an argument byte
                    if (r_cr_held) begin
                        ir1    = inline_char(r_inl, CH_CR);
                        n_inl  = ir1.st;
                        em_a_v = ir1.emit;
                        em_a   = ir1.res;
                    end
                    n_cr_held = 1'b1;
                end else begin
                    // held CR not before LF is an ordinary byte
                    if (r_cr_held) ir1 = inline_char(r_inl, CH_CR);
                    else           ir1 = '{st: r_inl, emit: 1'b0, res: '0};
                    ir2       = inline_char(ir1.st, c);
                    n_inl     = ir2.st;
                    n_cr_held = 1'b0;
                    em_a_v    = ir1.emit;
                    em_a      = ir1.res;
                    em_b_v    = ir2.emit;
                    em_b      = ir2.res;
                end
            end
            M_DISCARD: begin
                if (c == CH_LF) n_mode = M_IDLE;
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        // framing error: one error item, resync at next LF
        if (em_a_v && em_a == '0) begin
            em_a         = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            n_inl        = INL_CLEAR;
            n_cr_held    = 1'b0;
            n_acc        = '0;
            n_digit_seen = 1'b0;
            n_mode       = (c == CH_LF) ? M_IDLE : M_DISCARD;
        end

        // pack emitted items and mark the last one
        e0    = em_a_v ? em_a : em_b;
        e1    = em_b;
        e_cnt = 2'(em_a_v) + 2'(em_b_v);
        if (e_cnt == 2'd1) e0.run_last = 1'b1;
        if (e_cnt == 2'd2) e1.run_last = 1'b1;
    end

    // output port view of the queue head
    t_result head;
    assign head          = r_fifo[r_rd_ptr];
    assign o_arg_byte    = head.arg_byte;
    assign o_has_byte    = head.has_byte;
    assign o_arg_first   = head.arg_first;
    assign o_arg_last    = head.arg_last;
    assign o_cmd_last    = head.cmd_last;
    assign o_parse_error = head.parse_error;
    assign o_run_last    = head.run_last;

    logic [1:0] push_n;
    assign push_n = proceed ? e_cnt : 2'd0;

    // state, input register and result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_elems      <= '0;
            r_payl       <= '0;
            r_acc        <= '0;
            r_inl        <= INL_CLEAR;
            r_cr_held    <= 1'b0;
            r_digit_seen <= 1'b0;
            r_in_valid   <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            // input transfer
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (proceed) begin
                r_mode       <= n_mode;
                r_elems      <= n_elems;
                r_payl       <= n_payl;
                r_acc        <= n_acc;
                r_inl        <= n_inl;
                r_cr_held    <= n_cr_held;
                r_digit_seen <= n_digit_seen;
            end
            r_wr_ptr <= r_wr_ptr + Q_AW'(push_n);
            if (pop) r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            r_count  <= r_count + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);
        end
        // payload registers
        if (o_in_ready && i_in_valid) r_in_byte <= i_in_byte;
        if (push_n != 2'd0) r_fifo[r_wr_ptr] <= e0;
        if (push_n == 2'd2) r_fifo[r_wr_ptr + Q_AW'(1)] <= e1;
    end

endmodule
